// ===== src/bu2d_pkg.sv =====
package bu2d_pkg;

   // frame store geometry and pixel precision
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_WIDTH  = 64;
   localparam int PIXEL_BITS = 16;
   localparam int STORE_BITS = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

   localparam int ROW_IDX_BITS = $clog2(MAX_HEIGHT);
   localparam int COL_IDX_BITS = $clog2(MAX_WIDTH);
   localparam int STORE_DEPTH  = MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);

   // field widths
   localparam int COORD_BITS     = 12;
   localparam int FIELD_PIX_BITS = 16;
   localparam int SIZE_BITS      = 7;
   localparam int RATIO_BITS     = 24;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // fixed point
   localparam int FRAC_BITS    = 16;
   localparam int ONE_Q16      = 1 << FRAC_BITS;
   localparam int POS_BITS     = RATIO_BITS + COORD_BITS + 1;
   localparam int IDX_RAW_BITS = POS_BITS - 1 - FRAC_BITS;
   localparam int WEIGHT_BITS  = FRAC_BITS + 1;
   localparam int WT_BITS      = 2 * WEIGHT_BITS;
   localparam int ACC_BITS     = WT_BITS + 1 + FIELD_PIX_BITS;
   localparam int RES_BITS     = ACC_BITS - 2 * FRAC_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_HEIGHT     = 3'd0,
      CSR_IN_WIDTH      = 3'd1,
      CSR_RATIO_H       = 3'd2,
      CSR_RATIO_W       = 3'd3,
      CSR_ALIGN_CORNERS = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_COMPUTE = 1'b1
   } opcode_type;

endpackage

// ===== src/bu2d_req_if.sv =====
interface bu2d_req_if;
   import bu2d_pkg::*;

   logic                              valid;
   logic                              ready;
   opcode_type                        opcode;
   logic [COORD_BITS-1:0]             row;
   logic [COORD_BITS-1:0]             col;
   logic signed [FIELD_PIX_BITS-1:0]  pixel_in;

   modport source (output valid, opcode, row, col, pixel_in, input ready);
   modport sink (input valid, opcode, row, col, pixel_in, output ready);
endinterface

// ===== src/bu2d_rsp_if.sv =====
interface bu2d_rsp_if;
   import bu2d_pkg::*;

   logic                              valid;
   logic                              ready;
   logic signed [FIELD_PIX_BITS-1:0]  pixel_out;
   logic [COORD_BITS-1:0]             out_row;
   logic [COORD_BITS-1:0]             out_col;

   modport source (output valid, pixel_out, out_row, out_col, input ready);
   modport sink (input valid, pixel_out, out_row, out_col, output ready);
endinterface

// ===== src/bu2d_ram.sv =====
module bu2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bilinear_upsample_2d_unit.sv =====
// single-channel bilinear upscaler over a single-port frame store
// pixel write: the store is written at the edge of the transfer
// compute: the request passes the map, index, read and drain states; the four neighbour reads share
// the store's one port, so no new transfer is taken until a compute has finished, nor while
// a held result keeps the finished sum from entering the result register
// reset (synchronous, active high) restores the registers and empties the pipeline only
module bilinear_upsample_2d_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bu2d_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bu2d_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   bu2d_req_if.sink                             req_chan,
   bu2d_rsp_if.source                           rsp_chan
);
   import bu2d_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAP   = 5'b00010,
      ST_IDX   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(longint'(1) << 31);
   localparam longint PIX_HI = (longint'(1) << (PIXEL_BITS - 1)) - 1;
   localparam longint PIX_LO = -(longint'(1) << (PIXEL_BITS - 1));

   // configuration registers
   logic [SIZE_BITS-1:0]  in_height_ff;
   logic [SIZE_BITS-1:0]  in_width_ff;
   logic [RATIO_BITS-1:0] ratio_h_ff;
   logic [RATIO_BITS-1:0] ratio_w_ff;
   logic                  align_ff;

   // control
   state_type   state_ff, state_in;
   logic [1:0]  tap_ff, tap_in;
   logic        wt_valid_ff, wt_valid_in;
   logic        prod_valid_ff, prod_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [COORD_BITS-1:0]             row_ff, col_ff;
   logic [POS_BITS-1:0]               mul_h_ff, mul_h_in;
   logic [POS_BITS-1:0]               mul_w_ff, mul_w_in;
   logic [ROW_IDX_BITS-1:0]           r0_ff, r1_ff, r0_in, r1_in;
   logic [COL_IDX_BITS-1:0]           c0_ff, c1_ff, c0_in, c1_in;
   logic [WEIGHT_BITS-1:0]            a0_ff, a1_ff, b0_ff, b1_ff;
   logic [WEIGHT_BITS-1:0]            a0_in, a1_in, b0_in, b1_in;
   logic [WT_BITS-1:0]                wt_ff, wt_in;
   logic signed [ACC_BITS-1:0]        prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]        acc_ff, acc_in;
   logic signed [FIELD_PIX_BITS-1:0]  pix_out_ff, pix_out_in;
   logic [COORD_BITS-1:0]             out_row_ff, out_col_ff;

   // datapath signals
   logic                          req_xfer, rsp_free, load_rsp;
   logic [COORD_BITS:0]           op_h, op_w;
   logic [POS_BITS-2:0]           pos_h, pos_w;
   logic [IDX_RAW_BITS-1:0]       idx_h, idx_w;
   logic [ROW_IDX_BITS-1:0]       last_row;
   logic [COL_IDX_BITS-1:0]       last_col;
   logic [ROW_IDX_BITS-1:0]       rd_row;
   logic [COL_IDX_BITS-1:0]       rd_col;
   logic [WEIGHT_BITS-1:0]        wa, wb;
   logic [ADDR_BITS-1:0]          rd_addr, wr_addr, ram_addr;
   logic                          wr_in_range, ram_we;
   logic [STORE_BITS-1:0]         ram_rdata;
   logic signed [FIELD_PIX_BITS-1:0] rd_pix;
   logic signed [ACC_BITS-1:0]    rnd_sum;
   logic signed [RES_BITS-1:0]    res;

   // source position along one axis, UQ.16
   function automatic logic [POS_BITS-2:0] src_pos(input logic [POS_BITS-1:0] p,
                                                   input logic align);
      logic [POS_BITS-1:0] biased;
      biased = p - POS_BITS'(ONE_Q16);
      if (align) begin
         return p[POS_BITS-2:0];
      end else if (p < POS_BITS'(ONE_Q16)) begin
         return '0;
      end else begin
         return biased[POS_BITS-1:1];
      end
   endfunction

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // configuration writes, fields truncated to their register widths
   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff <= SIZE_BITS'(MAX_HEIGHT);
         in_width_ff  <= SIZE_BITS'(MAX_WIDTH);
         ratio_h_ff   <= RATIO_BITS'(ONE_Q16);
         ratio_w_ff   <= RATIO_BITS'(ONE_Q16);
         align_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IN_HEIGHT:     in_height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_IN_WIDTH:      in_width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_RATIO_H:       ratio_h_ff   <= csr_wdata[RATIO_BITS-1:0];
            CSR_RATIO_W:       ratio_w_ff   <= csr_wdata[RATIO_BITS-1:0];
            CSR_ALIGN_CORNERS: align_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // last valid row and column: a size of zero acts as one, oversize saturates
   always_comb begin
      if (in_height_ff == '0) begin
         last_row = '0;
      end else if (int'(in_height_ff) > MAX_HEIGHT) begin
         last_row = ROW_IDX_BITS'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_IDX_BITS'(in_height_ff - 1'b1);
      end
      if (in_width_ff == '0) begin
         last_col = '0;
      end else if (int'(in_width_ff) > MAX_WIDTH) begin
         last_col = COL_IDX_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_IDX_BITS'(in_width_ff - 1'b1);
      end
   end

   // map stage: aligned corners use ratio*d, half-pixel centres ratio*(2d+1)
   assign op_h     = align_ff ? {1'b0, row_ff} : {row_ff, 1'b1};
   assign op_w     = align_ff ? {1'b0, col_ff} : {col_ff, 1'b1};
   assign mul_h_in = POS_BITS'(ratio_h_ff) * POS_BITS'(op_h);
   assign mul_w_in = POS_BITS'(ratio_w_ff) * POS_BITS'(op_w);

   // index stage: integer part clamped to the image, fraction gives the weights
   always_comb begin
      pos_h = src_pos(mul_h_ff, align_ff);
      pos_w = src_pos(mul_w_ff, align_ff);
      idx_h = pos_h[POS_BITS-2:FRAC_BITS];
      idx_w = pos_w[POS_BITS-2:FRAC_BITS];
      r0_in = (idx_h > IDX_RAW_BITS'(last_row)) ? last_row : idx_h[ROW_IDX_BITS-1:0];
      c0_in = (idx_w > IDX_RAW_BITS'(last_col)) ? last_col : idx_w[COL_IDX_BITS-1:0];
      r1_in = (r0_in < last_row) ? r0_in + 1'b1 : r0_in;
      c1_in = (c0_in < last_col) ? c0_in + 1'b1 : c0_in;
      a1_in = {1'b0, pos_h[FRAC_BITS-1:0]};
      b1_in = {1'b0, pos_w[FRAC_BITS-1:0]};
      a0_in = WEIGHT_BITS'(ONE_Q16) - a1_in;
      b0_in = WEIGHT_BITS'(ONE_Q16) - b1_in;
   end

   // read stage: one neighbour per cycle, tap bit 1 picks the row, bit 0 the column
   assign rd_row  = tap_ff[1] ? r1_ff : r0_ff;
   assign rd_col  = tap_ff[0] ? c1_ff : c0_ff;
   assign wa      = tap_ff[1] ? a1_ff : a0_ff;
   assign wb      = tap_ff[0] ? b1_ff : b0_ff;
   assign wt_in   = WT_BITS'(wa) * WT_BITS'(wb);
   assign rd_addr = ADDR_BITS'(rd_row * MAX_WIDTH) + ADDR_BITS'(rd_col);

   // pixel writes go straight to the store on the transfer; out-of-range ones are dropped
   assign wr_in_range = (int'(req_chan.row) < MAX_HEIGHT) && (int'(req_chan.col) < MAX_WIDTH);
   assign wr_addr  = ADDR_BITS'(req_chan.row[ROW_IDX_BITS-1:0] * MAX_WIDTH)
                   + ADDR_BITS'(req_chan.col[COL_IDX_BITS-1:0]);
   assign ram_we   = req_xfer && (req_chan.opcode == OP_WRITE) && wr_in_range;
   assign ram_addr = (state_ff == ST_READ) ? rd_addr : wr_addr;

   bu2d_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_chan.pixel_in[STORE_BITS-1:0]),
      .rdata (ram_rdata)
   );

   // weight times pixel, then accumulate
   assign rd_pix  = FIELD_PIX_BITS'($signed(ram_rdata));
   assign prod_in = ACC_BITS'($signed({1'b0, wt_ff})) * ACC_BITS'(rd_pix);

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_IDX) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // round to nearest (ties upward), drop the Q0.32 fraction, saturate
   assign rnd_sum = acc_ff + ROUND_BIAS;
   assign res     = rnd_sum[ACC_BITS-1:2*FRAC_BITS];

   always_comb begin
      if (longint'(res) > PIX_HI) begin
         pix_out_in = FIELD_PIX_BITS'(PIX_HI);
      end else if (longint'(res) < PIX_LO) begin
         pix_out_in = FIELD_PIX_BITS'(PIX_LO);
      end else begin
         pix_out_in = FIELD_PIX_BITS'(res);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      wt_valid_in   = 1'b0;
      prod_valid_in = wt_valid_ff;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_chan.opcode == OP_COMPUTE)) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_IDX;
         end
         ST_IDX: begin
            tap_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            wt_valid_in = 1'b1;
            tap_in      = tap_ff + 1'b1;
            if (tap_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!wt_valid_ff && !prod_valid_ff && rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register parts the result transfer from the request side
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= '0;
         wt_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         wt_valid_ff   <= wt_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         row_ff <= req_chan.row;
         col_ff <= req_chan.col;
      end
      if (state_ff == ST_MAP) begin
         mul_h_ff <= mul_h_in;
         mul_w_ff <= mul_w_in;
      end
      if (state_ff == ST_IDX) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         c0_ff <= c0_in;
         c1_ff <= c1_in;
         a0_ff <= a0_in;
         a1_ff <= a1_in;
         b0_ff <= b0_in;
         b1_ff <= b1_in;
      end
      wt_ff   <= wt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (load_rsp) begin
         pix_out_ff <= pix_out_in;
         out_row_ff <= row_ff;
         out_col_ff <= col_ff;
      end
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = pix_out_ff;
   assign rsp_chan.out_row   = out_row_ff;
   assign rsp_chan.out_col   = out_col_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import bu2d_pkg::*;

   // one stored or interpolated pixel plus the output coordinate it belongs to
   typedef struct packed {
      logic signed [FIELD_PIX_BITS-1:0] pixel;
      logic [COORD_BITS-1:0]            row;
      logic [COORD_BITS-1:0]            col;
   } interp_result_type;

   // one line of the directed table: either a request transfer or a full register set
   typedef struct {
      bit                               is_cfg;
      opcode_type                       op;
      logic [COORD_BITS-1:0]            row;
      logic [COORD_BITS-1:0]            col;
      logic signed [FIELD_PIX_BITS-1:0] pix;
      bit                               has_lit;
      logic signed [FIELD_PIX_BITS-1:0] lit;
      logic [SIZE_BITS-1:0]             height;
      logic [SIZE_BITS-1:0]             width;
      logic [RATIO_BITS-1:0]            step_h;
      logic [RATIO_BITS-1:0]            step_w;
      logic                             align;
   } stim_row_type;

   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the pipeline
   localparam int ITEM_TARGET  = 950;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bu2d_req_if req_bus ();
   bu2d_rsp_if rsp_bus ();

   bilinear_upsample_2d_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // shadow of the block's registers and frame store
   logic [SIZE_BITS-1:0]             cfg_height;
   logic [SIZE_BITS-1:0]             cfg_width;
   logic [RATIO_BITS-1:0]            cfg_step_h;
   logic [RATIO_BITS-1:0]            cfg_step_w;
   logic                             cfg_align;
   logic signed [FIELD_PIX_BITS-1:0] pixel_mem [STORE_DEPTH];
   bit                               pixel_known [STORE_DEPTH];

   interp_result_type pending_pixels [$];   // interpolations still owed by the block
   stim_row_type      dir_table [$];        // directed stimulus, walked in order
   int unsigned items_sent;
   int unsigned mismatch_count;
   int unsigned burst_left;
   bit          long_hold_req;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs or drops a result
   initial begin
      #2_000_000;
      $display("bilinear_upsample_2d_unit regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------

   // size register as the block sees it: zero acts as one, too large saturates
   function automatic int unsigned fit_size(input logic [SIZE_BITS-1:0] v,
                                            input int unsigned limit);
      if (v == 0)
         return 1;
      return (v > limit) ? limit : v;
   endfunction

   // map one output coordinate to two source indices and their q1.16 weights
   function automatic void map_axis(input logic [RATIO_BITS-1:0] step,
                                    input logic [COORD_BITS-1:0] d,
                                    input int unsigned size,
                                    output int unsigned i0, output int unsigned i1,
                                    output longint w0, output longint w1);
      longint unsigned s;
      longint unsigned dd;
      longint unsigned twice;
      longint unsigned pos;
      longint unsigned idx;
      s  = step;
      dd = d;
      if (cfg_align) begin
         pos = s * dd;
      end else begin
         // half-pixel centres: (step*(2d+1) - 1.0) / 2, never below zero
         twice = s * (2 * dd + 1);
         pos   = (twice < ONE_Q16) ? 0 : (twice - ONE_Q16) >> 1;
      end
      idx = pos >> FRAC_BITS;
      w1  = longint'(pos & 64'hFFFF);
      w0  = ONE_Q16 - w1;
      if (idx > size - 1)
         idx = size - 1;
      i0 = int'(idx);
      i1 = (i0 < size - 1) ? i0 + 1 : i0;
   endfunction

   function automatic longint stored_px(input int unsigned r, input int unsigned c);
      return longint'(pixel_mem[r * MAX_WIDTH + c]);
   endfunction

   function automatic logic signed [FIELD_PIX_BITS-1:0] interp_pixel(
         input logic [COORD_BITS-1:0] r, input logic [COORD_BITS-1:0] c);
      int unsigned r0, r1, c0, c1;
      longint a0, a1, b0, b1;
      longint acc;
      longint res;
      longint lo;
      longint hi;
      lo = -(longint'(1) <<< (PIXEL_BITS - 1));
      hi = (longint'(1) <<< (PIXEL_BITS - 1)) - 1;
      map_axis(cfg_step_h, r, fit_size(cfg_height, MAX_HEIGHT), r0, r1, a0, a1);
      map_axis(cfg_step_w, c, fit_size(cfg_width, MAX_WIDTH), c0, c1, b0, b1);
      acc = a0 * b0 * stored_px(r0, c0) + a0 * b1 * stored_px(r0, c1)
          + a1 * b0 * stored_px(r1, c0) + a1 * b1 * stored_px(r1, c1);
      // round to nearest, ties upward, then drop the q0.32 fraction
      res = (acc + (longint'(1) <<< 31)) >>> 32;
      if (res < lo) res = lo;
      if (res > hi) res = hi;
      return res[FIELD_PIX_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic stim_row_type write_row(input logic [COORD_BITS-1:0] r,
                                              input logic [COORD_BITS-1:0] c,
                                              input logic signed [FIELD_PIX_BITS-1:0] p);
      stim_row_type s;
      s.is_cfg  = 1'b0;
      s.op      = OP_WRITE;
      s.row     = r;
      s.col     = c;
      s.pix     = p;
      s.has_lit = 1'b0;
      s.lit     = '0;
      return s;
   endfunction

   function automatic stim_row_type compute_row(input logic [COORD_BITS-1:0] r,
                                                input logic [COORD_BITS-1:0] c,
                                                input bit has_lit,
                                                input logic signed [FIELD_PIX_BITS-1:0] lit);
      stim_row_type s;
      s.is_cfg  = 1'b0;
      s.op      = OP_COMPUTE;
      s.row     = r;
      s.col     = c;
      s.pix     = '0;
      s.has_lit = has_lit;
      s.lit     = lit;
      return s;
   endfunction

   function automatic stim_row_type cfg_row(input logic [SIZE_BITS-1:0] h,
                                            input logic [SIZE_BITS-1:0] w,
                                            input logic [RATIO_BITS-1:0] sh,
                                            input logic [RATIO_BITS-1:0] sw,
                                            input logic al);
      stim_row_type s;
      s.is_cfg = 1'b1;
      s.op     = OP_WRITE;
      s.height = h;
      s.width  = w;
      s.step_h = sh;
      s.step_w = sw;
      s.align  = al;
      return s;
   endfunction

   // append one line at the end of the directed table
   function automatic void add_stim(input stim_row_type entry);
      dir_table.insert(dir_table.size(), entry);
   endfunction

   // ratio choice: the corner values, unity, a realistic upscale step, or anything
   function automatic logic [RATIO_BITS-1:0] pick_ratio();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return RATIO_BITS'(ONE_Q16);
         3:       return RATIO_BITS'($urandom);
         default: return RATIO_BITS'($urandom_range(24'h001000, 24'h010000));
      endcase
   endfunction

   // one register write per cycle, the enable stays high across back-to-back writes
   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
   endtask

   task automatic apply_config(input logic [SIZE_BITS-1:0] h, input logic [SIZE_BITS-1:0] w,
                               input logic [RATIO_BITS-1:0] sh,
                               input logic [RATIO_BITS-1:0] sw, input logic al);
      put_reg(CSR_IN_HEIGHT, CSR_DATA_BITS'(h));
      put_reg(CSR_IN_WIDTH, CSR_DATA_BITS'(w));
      put_reg(CSR_RATIO_H, CSR_DATA_BITS'(sh));
      put_reg(CSR_RATIO_W, CSR_DATA_BITS'(sw));
      put_reg(CSR_ALIGN_CORNERS, CSR_DATA_BITS'(al));
      @(negedge clock);
      csr_we     <= 1'b0;
      cfg_height  = h;
      cfg_width   = w;
      cfg_step_h  = sh;
      cfg_step_w  = sw;
      cfg_align   = al;
   endtask

   // stop offering, let every owed result out and give the pipeline time to settle
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one request and block until its transfer; bursts with random gaps between
   task automatic send_item(input opcode_type op, input logic [COORD_BITS-1:0] r,
                            input logic [COORD_BITS-1:0] c,
                            input logic signed [FIELD_PIX_BITS-1:0] p,
                            input bit has_lit, input logic signed [FIELD_PIX_BITS-1:0] lit);
      int unsigned gap;
      interp_result_type e;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.row      <= r;
      req_bus.col      <= c;
      req_bus.pixel_in <= p;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      // transfer taken: bring the shadow up to date in request order
      if (op == OP_WRITE) begin
         if (r < MAX_HEIGHT && c < MAX_WIDTH) begin
            pixel_mem[r * MAX_WIDTH + c]   = p;
            pixel_known[r * MAX_WIDTH + c] = 1'b1;
         end
      end else begin
         e.pixel = has_lit ? lit : interp_pixel(r, c);
         e.row   = r;
         e.col   = c;
         pending_pixels.insert(pending_pixels.size(), e);
      end
      items_sent++;
   endtask

   // ---------------------------------------------------------------------------------
   // receiver: stall pattern of its own, plus one long hold-off on request
   // ---------------------------------------------------------------------------------
   initial begin
      int unsigned cyc;
      int unsigned mode;
      bit          long_hold_done;
      cyc            = 0;
      mode           = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready  = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (long_hold_req && !long_hold_done) begin
            // hold the result side shut while the sender keeps offering
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (cyc % 50 == 0)
               mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // result checker: each transfer against the oldest owed interpolation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      interp_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("result transfer with nothing owed: row %0d col %0d pixel %0d",
                   rsp_bus.out_row, rsp_bus.out_col, rsp_bus.pixel_out);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pixel_out !== want.pixel) begin
               $error("pixel_out: expected %0d, got %0d", want.pixel, rsp_bus.pixel_out);
               mismatch_count++;
            end
            if (rsp_bus.out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_bus.out_row);
               mismatch_count++;
            end
            if (rsp_bus.out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_bus.out_col);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      stim_row_type          s;
      int unsigned           phase_no;
      int unsigned           n;
      int unsigned           sel;
      int unsigned           eh;
      int unsigned           ew;
      logic [SIZE_BITS-1:0]  h_cfg;
      logic [SIZE_BITS-1:0]  w_cfg;
      logic [COORD_BITS-1:0] r;
      logic [COORD_BITS-1:0] c;

      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_IN_HEIGHT;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_WRITE;
      req_bus.row      = '0;
      req_bus.col      = '0;
      req_bus.pixel_in = '0;
      items_sent       = 0;
      mismatch_count   = 0;
      burst_left       = 0;
      long_hold_req    = 1'b0;
      phase_no         = 0;

      // register values after reset
      cfg_height = SIZE_BITS'(64);
      cfg_width  = SIZE_BITS'(64);
      cfg_step_h = RATIO_BITS'(ONE_Q16);
      cfg_step_w = RATIO_BITS'(ONE_Q16);
      cfg_align  = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset settings first: unity step, 64 x 64 image, half-pixel
      add_stim(write_row(0, 0, 16'sd32767));
      add_stim(write_row(0, 1, -16'sd32768));
      add_stim(write_row(1, 0, 16'sh1234));
      add_stim(write_row(1, 1, -16'sd1));
      add_stim(compute_row(0, 0, 1'b1, 16'sd32767));       // weight all on one pixel
      add_stim(write_row(63, 63, -16'sd32768));
      add_stim(compute_row(63, 63, 1'b1, -16'sd32768));    // last row and column
      add_stim(compute_row(4095, 4095, 1'b1, -16'sd32768)); // past the image, clamped
      // writes outside the store leave it untouched
      add_stim(write_row(4095, 63, 16'sd5));
      add_stim(write_row(63, 4095, 16'sd7));
      add_stim(write_row(64, 64, 16'sd9));
      add_stim(compute_row(63, 63, 1'b1, -16'sd32768));
      // aligned corners with a half step: four equal weights
      add_stim(cfg_row(2, 2, 24'h008000, 24'h008000, 1'b1));
      add_stim(compute_row(1, 1, 1'b0, '0));
      add_stim(compute_row(4095, 0, 1'b0, '0));
      // zero height acts as one row, largest step runs off the right edge
      add_stim(cfg_row(0, 2, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
      add_stim(compute_row(4095, 4095, 1'b0, '0));
      add_stim(compute_row(0, 0, 1'b0, '0));
      // oversized height saturates, zero step pins every pixel to the origin
      add_stim(cfg_row(127, 1, 24'h000000, 24'h000000, 1'b1));
      add_stim(compute_row(2000, 17, 1'b0, '0));
      // half-pixel mapping below zero is clamped, then a fractional weight
      add_stim(cfg_row(1, 64, 24'h018000, 24'h006000, 1'b0));
      add_stim(compute_row(0, 0, 1'b0, '0));
      add_stim(compute_row(0, 1, 1'b0, '0));

      foreach (dir_table[i]) begin
         s = dir_table[i];
         if (s.is_cfg) begin
            wait_idle();
            apply_config(s.height, s.width, s.step_h, s.step_w, s.align);
         end else begin
            send_item(s.op, s.row, s.col, s.pix, s.has_lit, s.lit);
         end
      end

      // random phases: new settings, fill the image region, then a mix of transfers
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 7))
            0: begin
               h_cfg = SIZE_BITS'($urandom_range(64, 127));
               w_cfg = SIZE_BITS'($urandom_range(0, 2));
            end
            1: begin
               h_cfg = SIZE_BITS'($urandom_range(0, 2));
               w_cfg = SIZE_BITS'($urandom_range(64, 127));
            end
            default: begin
               h_cfg = SIZE_BITS'($urandom_range(0, 9));
               w_cfg = SIZE_BITS'($urandom_range(0, 9));
            end
         endcase
         apply_config(h_cfg, w_cfg, pick_ratio(), pick_ratio(), 1'($urandom_range(0, 1)));
         eh = fit_size(h_cfg, MAX_HEIGHT);
         ew = fit_size(w_cfg, MAX_WIDTH);

         // every neighbour a compute can reach must hold a written pixel
         for (int unsigned fr = 0; fr < eh; fr++)
            for (int unsigned fc = 0; fc < ew; fc++)
               if (!pixel_known[fr * MAX_WIDTH + fc])
                  send_item(OP_WRITE, COORD_BITS'(fr), COORD_BITS'(fc),
                            FIELD_PIX_BITS'($urandom), 1'b0, '0);

         if (phase_no == 2)
            long_hold_req = 1'b1;

         n = $urandom_range(30, 90);
         repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
               // mostly coordinates near the scaled image, some anywhere
               r = ($urandom_range(0, 9) < 7) ? COORD_BITS'($urandom_range(0, 2 * eh + 3))
                                              : COORD_BITS'($urandom);
               c = ($urandom_range(0, 9) < 7) ? COORD_BITS'($urandom_range(0, 2 * ew + 3))
                                              : COORD_BITS'($urandom);
               send_item(OP_COMPUTE, r, c, FIELD_PIX_BITS'($urandom), 1'b0, '0);
            end else if (sel < 90) begin
               send_item(OP_WRITE, COORD_BITS'($urandom_range(0, MAX_HEIGHT - 1)),
                         COORD_BITS'($urandom_range(0, MAX_WIDTH - 1)),
                         FIELD_PIX_BITS'($urandom), 1'b0, '0);
            end else begin
               // full-range write, mostly lands outside the store
               send_item(OP_WRITE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         FIELD_PIX_BITS'($urandom), 1'b0, '0);
            end
         end
         phase_no++;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("bilinear_upsample_2d_unit regression: pass");
      end else begin
         $display("bilinear_upsample_2d_unit regression: fail");
      end
      $finish;
   end

endmodule
